FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the subdivision grid RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Plain property, checked on every clock edge outside reset.
`define ISG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Overlapping implication, checked outside reset.
`define ISG_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |-> cons) else $error(msg);
`else
`define ISG_ASSERT(lbl, clk, rst, prop, msg)
`define ISG_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/isg_pkg.sv
// ----------------------------------------------------------------------------
// isg_pkg
// Shared widths, register indexes, controller states and command/status types.
// ----------------------------------------------------------------------------
package isg_pkg;

  localparam int BP_W       = 12;  // breakpoint_count and interval index
  localparam int TGT_W      = 16;  // target_steps
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_W      = BP_W; // divisor width of the shared divider

  localparam logic [CFG_IDX_W-1:0] CFG_BREAKPOINT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_STEPS     = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DERIVE,
    S_PREP,
    S_DIVIDE,
    S_EMIT
  } isg_state_t;

  typedef struct packed {
    logic cfg_write;     // capture a register write
    logic derive_clear;  // counts become zero
    logic derive_start;  // start surplus / breakpoint_count
    logic derive_load;   // load base and extra counts from divider
    logic item_load;     // capture a breakpoint request
    logic div_start_gap; // start gap / (inserts + 1)
    logic step_load;     // load step and first interior point
    logic emit_adv;      // a result was taken
  } isg_cmd_t;

  typedef struct packed {
    logic derive_trivial;
    logic div_done;
    logic no_inserts;
    logic run_last;
  } isg_status_t;

endpackage

FILE: rtl/isg_intf.sv
// ----------------------------------------------------------------------------
// isg_intf
// Valid/ready channel interfaces: breakpoint input, grid output, register write.
// ----------------------------------------------------------------------------
interface isg_in_if #(
  parameter int TIME_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] breakpoint_time;

  modport source (output valid, output breakpoint_time, input ready);
  modport sink   (input valid, input breakpoint_time, output ready);
endinterface

interface isg_out_if #(
  parameter int TIME_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] grid_time;
  logic                  run_last;
  logic                  schedule_last;

  modport source (output valid, output grid_time, output run_last, output schedule_last,
                  input ready);
  modport sink   (input valid, input grid_time, input run_last, input schedule_last,
                  output ready);
endinterface

interface isg_cfg_if import isg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/isg_divider.sv
// ----------------------------------------------------------------------------
// isg_divider
// Restoring divider, one quotient bit per cycle; done pulses after NUM_W steps.
// ----------------------------------------------------------------------------
module isg_divider #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem, quo[NUM_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(NUM_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // shift one dividend bit into the partial remainder, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (running) begin
      if (!diff[DEN_W]) begin
        rem <= diff[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: rtl/isg_datapath.sv
// ----------------------------------------------------------------------------
// isg_datapath
// Registers, schedule state, shared divider and grid point accumulator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isg_datapath import isg_pkg::*; #(
  parameter int TIME_WIDTH = 32,
  parameter int MAX_RUN    = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  isg_cmd_t              cmd,
  output isg_status_t           st,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [TIME_WIDTH-1:0] in_time,
  output logic [TIME_WIDTH-1:0] out_time,
  output logic                  out_run_last,
  output logic                  out_schedule_last
);

  localparam int RUN_W = $clog2(MAX_RUN);
  localparam logic [TIME_WIDTH-1:0] CAP_T = TIME_WIDTH'(MAX_RUN - 1);
  localparam logic [RUN_W:0]        CAP_R = (RUN_W + 1)'(MAX_RUN - 1);

  // schedule state
  logic [BP_W-1:0]       bp_count;
  logic [TGT_W-1:0]      target;
  logic [TIME_WIDTH-1:0] prev_time;
  logic [BP_W-1:0]       interval_index;
  logic [RUN_W-1:0]      base_inserts;
  logic [BP_W-1:0]       extra_intervals;

  // per-request working registers
  logic [TIME_WIDTH-1:0] bp_time;
  logic [RUN_W-1:0]      inserts;
  logic [TIME_WIDTH-1:0] step;
  logic [TIME_WIDTH-1:0] point;
  logic [RUN_W-1:0]      run_idx;

  logic [TGT_W-1:0]      surplus;
  logic [TIME_WIDTH-1:0] gap;
  logic [RUN_W:0]        ins_raw;
  logic [TIME_WIDTH-1:0] div_dividend;
  logic [DIV_W-1:0]      div_divisor;
  logic                  div_start;
  logic                  div_done;
  logic [TIME_WIDTH-1:0] div_quo;
  logic [DIV_W-1:0]      div_rem;
  logic                  final_bp;
  logic                  run_last;

  assign surplus  = target - TGT_W'(bp_count);
  assign gap      = (bp_time >= prev_time) ? (bp_time - prev_time) : '0;
  assign ins_raw  = {1'b0, base_inserts} + (RUN_W + 1)'(interval_index < extra_intervals);
  assign final_bp = (bp_count != '0) &&
                    (({1'b0, interval_index} + (BP_W + 1)'(1)) >= {1'b0, bp_count});
  assign run_last = (run_idx == inserts);

  assign div_start    = cmd.derive_start | cmd.div_start_gap;
  assign div_dividend = cmd.derive_start ? TIME_WIDTH'(surplus) : gap;
  assign div_divisor  = cmd.derive_start ? bp_count : (DIV_W'(inserts) + DIV_W'(1));

  isg_divider #(
    .NUM_W (TIME_WIDTH),
    .DEN_W (DIV_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bp_count        <= '0;
      target          <= '0;
      prev_time       <= '0;
      interval_index  <= '0;
      base_inserts    <= '0;
      extra_intervals <= '0;
    end else begin
      if (cmd.cfg_write) begin
        case (cfg_index)
          CFG_BREAKPOINT_COUNT: bp_count <= cfg_data[BP_W-1:0];
          CFG_TARGET_STEPS:     target   <= cfg_data[TGT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.derive_clear) begin
        base_inserts    <= '0;
        extra_intervals <= '0;
      end
      if (cmd.derive_load) begin
        base_inserts    <= (div_quo > CAP_T) ? CAP_T[RUN_W-1:0] : div_quo[RUN_W-1:0];
        extra_intervals <= div_rem;
      end
      if (cmd.emit_adv && run_last) begin
        if (final_bp) begin
          prev_time      <= '0;
          interval_index <= '0;
        end else begin
          prev_time <= bp_time;
          if (bp_count != '0) begin
            interval_index <= interval_index + BP_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      bp_time <= in_time;
      inserts <= (ins_raw > CAP_R) ? CAP_R[RUN_W-1:0] : ins_raw[RUN_W-1:0];
      run_idx <= '0;
    end
    if (cmd.step_load) begin
      step  <= div_quo;
      point <= prev_time + div_quo;
    end
    if (cmd.emit_adv && !run_last) begin
      point   <= point + step;
      run_idx <= run_idx + RUN_W'(1);
    end
  end

  assign st.derive_trivial = (bp_count == '0) || (target <= TGT_W'(bp_count));
  assign st.div_done       = div_done;
  assign st.no_inserts     = (inserts == '0);
  assign st.run_last       = run_last;

  assign out_time          = run_last ? bp_time : point;
  assign out_run_last      = run_last;
  assign out_schedule_last = run_last && final_bp;

  `ISG_ASSERT_IMPL(a_point_in_gap, clk, rst, cmd.emit_adv && !run_last && (bp_time >= prev_time), point <= bp_time, "interior point passed its breakpoint")
  `ISG_ASSERT_IMPL(a_run_idx_bound, clk, rst, cmd.emit_adv, run_idx <= inserts, "run index beyond insert count")
  `ISG_ASSERT(a_first_point, clk, rst, cmd.step_load |=> point >= prev_time, "first interior point wrapped")

endmodule

FILE: rtl/isg_ctrl.sv
// ----------------------------------------------------------------------------
// isg_ctrl
// Sequencer: register writes, count derivation, gap division, result emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isg_ctrl import isg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  isg_status_t st,
  output isg_cmd_t    cmd
);

  isg_state_t state;
  isg_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cfg_ready  = 1'b0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
          state_next    = S_CALC;
        end else if (in_valid) begin
          cmd.item_load = 1'b1;
          state_next    = S_PREP;
        end
      end
      S_CALC: begin
        if (st.derive_trivial) begin
          cmd.derive_clear = 1'b1;
          state_next       = S_IDLE;
        end else begin
          cmd.derive_start = 1'b1;
          state_next       = S_DERIVE;
        end
      end
      S_DERIVE: begin
        if (st.div_done) begin
          cmd.derive_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_PREP: begin
        if (st.no_inserts) begin
          state_next = S_EMIT;
        end else begin
          cmd.div_start_gap = 1'b1;
          state_next        = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (st.div_done) begin
          cmd.step_load = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          if (st.run_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ISG_ASSERT(a_run_end, clk, rst, (state == S_EMIT && out_ready && st.run_last) |=> state == S_IDLE, "did not return to idle after breakpoint")
  `ISG_ASSERT_IMPL(a_done_waited, clk, rst, st.div_done, state == S_DERIVE || state == S_DIVIDE, "divider finished with nobody waiting")
  `ISG_ASSERT_IMPL(a_derive_nonzero, clk, rst, cmd.derive_start, !st.derive_trivial, "derivation started with zero divisor")

endmodule

FILE: rtl/interval_subdivision_grid_unit.sv
// ----------------------------------------------------------------------------
// interval_subdivision_grid_unit
// Refines a breakpoint schedule into evenly spaced grid times per interval.
// ----------------------------------------------------------------------------
// Usage:
//   cfg        : register writes (index 0 breakpoint_count, 1 target_steps).
//                Other indexes are accepted and ignored. Each write re-derives
//                the per-interval counts; cfg and breakpoint ready stay low while
//                the counts are derived, and while the shared serial divider
//                runs when something is to be added.
//   breakpoint : one breakpoint time (Q8.24) per request, leading zero implied.
//   grid       : inserts + 1 results per breakpoint; interior points first,
//                the breakpoint itself last with run_last set.
// Timing: a request passes a setup state, then the serial divider
//   (skipped when the interval gets no interior points), then one result
//   per cycle while grid.ready is high, then a return to idle.
//   The bit-serial divider sets the floor on the time per breakpoint.
// Reset clears the registers, the previous time and the interval index.
// A stalled receiver holds the current result and the rest of the run;
// no new request is taken until the run is delivered.
// ----------------------------------------------------------------------------
module interval_subdivision_grid_unit import isg_pkg::*; #(
  parameter int TIME_WIDTH = 32,
  parameter int MAX_RUN    = 64
) (
  input logic      clk,
  input logic      rst,
  isg_cfg_if.sink  cfg,
  isg_in_if.sink   breakpoint,
  isg_out_if.source grid
);

  // command and status between sequencer and datapath
  isg_cmd_t    cmd;
  isg_status_t st;

  isg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .in_valid  (breakpoint.valid),
    .in_ready  (breakpoint.ready),
    .out_valid (grid.valid),
    .out_ready (grid.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath holds the schedule state and drives the result payload
  isg_datapath #(
    .TIME_WIDTH (TIME_WIDTH),
    .MAX_RUN    (MAX_RUN)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .st                (st),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .in_time           (breakpoint.breakpoint_time),
    .out_time          (grid.grid_time),
    .out_run_last      (grid.run_last),
    .out_schedule_last (grid.schedule_last)
  );

endmodule

FILE: dv/isg_grid_checker.sv
// ----------------------------------------------------------------------------
// isg_grid_checker
// Watches the register, breakpoint and grid channels of the subdivision unit,
// predicts every grid point of each accepted request and compares in order.
// ----------------------------------------------------------------------------
module isg_grid_checker import isg_pkg::*; #(
  parameter int TIME_WIDTH = 32,
  parameter int MAX_RUN    = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  bp_valid,
  input  logic                  bp_ready,
  input  logic [TIME_WIDTH-1:0] bp_time,
  input  logic                  grid_valid,
  input  logic                  grid_ready,
  input  logic [TIME_WIDTH-1:0] grid_time,
  input  logic                  grid_run_last,
  input  logic                  grid_schedule_last,
  output int                    fail_count,
  output int                    pending,
  output int                    results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int INSERT_CAP = MAX_RUN - 1;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] grid_time;
    logic                  run_last;
    logic                  schedule_last;
  } grid_point_t;

  grid_point_t           expected_grid[$];
  logic [BP_W-1:0]       n_breaks;
  logic [TGT_W-1:0]      n_target;
  logic [TIME_WIDTH-1:0] last_time;
  logic [BP_W-1:0]       interval_no;
  int unsigned           base_fill;
  int unsigned           extra_fill;
  int                    fails;
  int                    seen;

  // Spread the surplus of grid steps over the intervals of one schedule.
  function automatic void derive_fill();
    int unsigned surplus;
    int unsigned base;
    base       = 0;
    extra_fill = 0;
    if (n_breaks != 0 && n_target > n_breaks) begin
      surplus    = int'(n_target) - int'(n_breaks);
      base       = surplus / n_breaks;
      extra_fill = surplus % n_breaks;
    end
    base_fill = (base > INSERT_CAP) ? INSERT_CAP : base;
  endfunction

  function automatic void take_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_BREAKPOINT_COUNT) begin
      n_breaks = val[BP_W-1:0];
      derive_fill();
    end else if (idx == CFG_TARGET_STEPS) begin
      n_target = val[TGT_W-1:0];
      derive_fill();
    end
  endfunction

  // Queue the interior points of one interval and then the breakpoint itself.
  function automatic void push_run(logic [TIME_WIDTH-1:0] t);
    int unsigned           inserts;
    logic [TIME_WIDTH-1:0] gap;
    logic [TIME_WIDTH-1:0] pitch;
    logic [TIME_WIDTH-1:0] acc;
    logic                  ends_sched;
    grid_point_t           pt;
    inserts = base_fill;
    if (interval_no < extra_fill) inserts++;
    if (inserts > INSERT_CAP) inserts = INSERT_CAP;
    gap   = (t >= last_time) ? (t - last_time) : '0;
    pitch = gap / TIME_WIDTH'(inserts + 1);
    acc   = last_time;
    for (int j = 0; j < inserts; j++) begin
      acc              = acc + pitch;
      pt.grid_time     = acc;
      pt.run_last      = 1'b0;
      pt.schedule_last = 1'b0;
      expected_grid.push_back(pt);
    end
    ends_sched = (n_breaks != 0) && (int'(interval_no) + 1 >= int'(n_breaks));
    pt.grid_time     = t;
    pt.run_last      = 1'b1;
    pt.schedule_last = ends_sched;
    expected_grid.push_back(pt);
    if (ends_sched) begin
      last_time   = '0;
      interval_no = '0;
    end else begin
      last_time = t;
      if (n_breaks != 0) interval_no = interval_no + 1'b1;
    end
  endfunction

  function automatic void check_point();
    grid_point_t want;
    seen++;
    if (expected_grid.size() == 0) begin
      fails++;
      $display("%0t: grid result with none expected: actual %h run_last %b schedule_last %b",
               $time, grid_time, grid_run_last, grid_schedule_last);
      return;
    end
    want = expected_grid.pop_front();
    if (grid_time !== want.grid_time) begin
      fails++;
      $display("%0t: grid_time mismatch: expected %h, actual %h",
               $time, want.grid_time, grid_time);
    end
    if (grid_run_last !== want.run_last) begin
      fails++;
      $display("%0t: run_last mismatch: expected %b, actual %b",
               $time, want.run_last, grid_run_last);
    end
    if (grid_schedule_last !== want.schedule_last) begin
      fails++;
      $display("%0t: schedule_last mismatch: expected %b, actual %b",
               $time, want.schedule_last, grid_schedule_last);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      n_breaks    = '0;
      n_target    = '0;
      last_time   = '0;
      interval_no = '0;
      fails       = 0;
      seen        = 0;
      expected_grid.delete();
      derive_fill();
    end else begin
      if (grid_valid && grid_ready) check_point();
      if (cfg_valid && cfg_ready) take_write(cfg_index, cfg_data);
      if (bp_valid && bp_ready) push_run(bp_time);
    end
    fail_count   <= fails;
    pending      <= expected_grid.size();
    results_seen <= seen;
  end

endmodule

FILE: dv/interval_subdivision_grid_unit_tb.sv
// ----------------------------------------------------------------------------
// interval_subdivision_grid_unit_tb
// Drives breakpoint schedules and register settings into the subdivision unit
// under three idling mixes and one long output hold-off; the checker beside the
// block predicts and compares every grid point, this top gives the verdict.
// ----------------------------------------------------------------------------
module interval_subdivision_grid_unit_tb import isg_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIME_WIDTH = 32;
  localparam int MAX_RUN    = 64;
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 4 * TIME_WIDTH;

  // Register indexes the block accepts and ignores.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  logic clk;
  logic rst;

  isg_cfg_if                           cfg_ch ();
  isg_in_if  #(.TIME_WIDTH(TIME_WIDTH)) bp_ch ();
  isg_out_if #(.TIME_WIDTH(TIME_WIDTH)) grid_ch ();

  int fail_count;
  int pending;
  int results_seen;

  int send_idle;    // percent of cycles the sender holds back
  int recv_idle;    // percent of cycles the receiver holds back
  bit hold_req;     // ask the receiver for one long hold-off
  bit hold_done;
  int requests_sent;
  int writes_done;

  interval_subdivision_grid_unit #(
    .TIME_WIDTH(TIME_WIDTH),
    .MAX_RUN   (MAX_RUN)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_ch),
    .breakpoint(bp_ch),
    .grid      (grid_ch)
  );

  isg_grid_checker #(
    .TIME_WIDTH(TIME_WIDTH),
    .MAX_RUN   (MAX_RUN)
  ) u_checker (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_ch.valid),
    .cfg_ready         (cfg_ch.ready),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .bp_valid          (bp_ch.valid),
    .bp_ready          (bp_ch.ready),
    .bp_time           (bp_ch.breakpoint_time),
    .grid_valid        (grid_ch.valid),
    .grid_ready        (grid_ch.ready),
    .grid_time         (grid_ch.grid_time),
    .grid_run_last     (grid_ch.run_last),
    .grid_schedule_last(grid_ch.schedule_last),
    .fail_count        (fail_count),
    .pending           (pending),
    .results_seen      (results_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("interval_subdivision_grid_unit_tb failed");
    $finish;
  end

  // Receiver: drop ready at random, or hold it low for one long stretch when
  // asked, counting the stretch here so the sender keeps pushing requests.
  initial begin
    grid_ch.ready = 1'b0;
    hold_done     = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        grid_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        grid_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Offer one breakpoint request and hold it until the block takes it.
  // Entered and left at a falling edge; valid stays high on exit so that
  // back-to-back requests need no second assignment in one step.
  task automatic drive_break(input logic [TIME_WIDTH-1:0] t);
    while ($urandom_range(99) < send_idle) begin
      bp_ch.valid           <= 1'b0;
      bp_ch.breakpoint_time <= $urandom;
      @(negedge clk);
    end
    bp_ch.valid           <= 1'b1;
    bp_ch.breakpoint_time <= t;
    @(posedge clk);
    while (!bp_ch.ready) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  // Drop the request line and wait until every expected grid point is out.
  task automatic settle();
    bp_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // One register write; call only while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    writes_done++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // One random schedule: pick the registers, then send nondecreasing
  // breakpoints with a little noise and the odd schedule cut short.
  task automatic run_schedule();
    int unsigned       nb;
    int unsigned       tg;
    int unsigned       mode;
    int unsigned       count;
    longint unsigned   cur;
    longint unsigned   span;
    longint unsigned   incr;
    logic [TIME_WIDTH-1:0] t;
    mode = $urandom_range(9);
    nb   = (mode == 9) ? 0 : ((mode == 8) ? $urandom_range(7, 12) : $urandom_range(1, 6));
    if (mode <= 1)      tg = $urandom_range(0, nb);
    else if (mode == 2) tg = $urandom_range(0, 16'hFFFF);
    else                tg = nb + $urandom_range(0, nb * 24 + 8);
    settle();
    // Junk in the upper data bits of the count write must be masked off.
    if ($urandom_range(1)) begin
      write_reg(CFG_BREAKPOINT_COUNT, {4'($urandom), 12'(nb)});
      write_reg(CFG_TARGET_STEPS, 16'(tg));
    end else begin
      write_reg(CFG_TARGET_STEPS, 16'(tg));
      write_reg(CFG_BREAKPOINT_COUNT, {4'($urandom), 12'(nb)});
    end
    if ($urandom_range(5) == 0)
      write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, 16'($urandom));
    count = (nb == 0) ? $urandom_range(1, 3) : nb;
    if ($urandom_range(9) == 0) count = $urandom_range(1, count);
    cur = 0;
    for (int unsigned k = 0; k < count; k++) begin
      span = (64'(TIME_MAX) - cur) / (count - k);
      case ($urandom_range(3))
        0:       incr = $urandom_range(0, 255);
        1:       incr = longint'($urandom) % (span + 1);
        2:       incr = span;
        default: begin
          incr = longint'($urandom >> $urandom_range(0, 31));
          if (incr > span) incr = span;
        end
      endcase
      cur = cur + incr;
      if (k == count - 1 && $urandom_range(3) == 0) cur = 64'(TIME_MAX);
      t = TIME_WIDTH'(cur);
      // Noise: a full-range time, often below the previous one.
      if ($urandom_range(9) == 0) begin
        t   = $urandom;
        cur = t;
      end
      drive_break(t);
    end
  endtask

  initial begin
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    bp_ch.valid           = 1'b0;
    bp_ch.breakpoint_time = '0;
    hold_req              = 1'b0;
    requests_sent         = 0;
    writes_done           = 0;
    send_idle             = 36;
    recv_idle             = 71;
    rst                   = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Registers at reset: pass-through, no schedule end, decreasing input.
    drive_break(32'h0100_0000);
    drive_break(32'h0000_0000);

    // Target equal to the count: nothing to add, schedule ends at the 4th.
    settle();
    write_reg(CFG_BREAKPOINT_COUNT, 16'd4);
    write_reg(CFG_TARGET_STEPS, 16'd4);
    drive_break(32'h0000_0001);
    drive_break(32'h0000_0002);
    drive_break(32'h0000_0003);
    drive_break(TIME_MAX);

    // Base plus one extra interval; then a zero gap and a decreasing time.
    settle();
    write_reg(CFG_BREAKPOINT_COUNT, 16'd3);
    write_reg(CFG_TARGET_STEPS, 16'd100);
    drive_break(32'h0300_0000);
    drive_break(32'h0300_0000);
    drive_break(32'h0200_0000);

    // Saturated interval over the widest gap, then a new schedule at zero.
    settle();
    write_reg(CFG_BREAKPOINT_COUNT, 16'd1);
    write_reg(CFG_TARGET_STEPS, 16'hFFFF);
    drive_break(TIME_MAX);
    drive_break(32'h0000_0000);

    // Zero breakpoint count: pass-through even with a large target.
    settle();
    write_reg(CFG_BREAKPOINT_COUNT, 16'd0);
    write_reg(CFG_TARGET_STEPS, 16'd500);
    drive_break(32'h00AB_CDEF);

    // Change the target mid-schedule: counts change, position is kept.
    settle();
    write_reg(CFG_BREAKPOINT_COUNT, 16'd5);
    write_reg(CFG_TARGET_STEPS, 16'd20);
    drive_break(32'h0010_0000);
    drive_break(32'h0080_0000);
    settle();
    write_reg(CFG_TARGET_STEPS, 16'd30);
    drive_break(32'h0180_0000);
    drive_break(32'h0400_0000);
    drive_break(32'h7FFF_FFFF);

    // Writes to spare indexes must change nothing.
    settle();
    write_reg(CFG_SPARE_2, 16'hFFFF);
    write_reg(CFG_SPARE_3, 16'h0000);
    drive_break(32'h5555_5555);

    // Largest count and target, written mid-schedule.
    settle();
    write_reg(CFG_BREAKPOINT_COUNT, 16'hFFFF);
    write_reg(CFG_TARGET_STEPS, 16'hFFFF);
    drive_break(32'h0000_0001);
    drive_break(32'hAAAA_AAAA);

    // Random schedules: sender sparse, receiver sparser.
    while (requests_sent < 56) run_schedule();

    // Swap the idling of the two sides.
    send_idle = 71;
    recv_idle = 36;
    while (requests_sent < 92) run_schedule();

    // No idling; start with a long output hold-off on full runs so the
    // block fills up and stalls its request input.
    send_idle = 0;
    recv_idle = 0;
    settle();
    write_reg(CFG_BREAKPOINT_COUNT, 16'd2);
    write_reg(CFG_TARGET_STEPS, 16'd200);
    hold_req = 1'b1;
    for (int k = 0; k < 6; k++) drive_break(32'h0100_0000 * (k % 2 + 1) + $urandom_range(255));
    while (requests_sent < 124) run_schedule();

    // Drain, then allow for the block's own latency.
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d breakpoint requests, %0d grid results and %0d register writes,",
             requests_sent, results_seen, writes_done);
    $display("under sender/receiver idling of 36/71, 71/36 and none, plus a long output hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("interval_subdivision_grid_unit_tb passed");
    end else begin
      $display("interval_subdivision_grid_unit_tb failed");
    end
    $finish;
  end

endmodule
